[src/dbe_pkg.sv]
// ----------------------------------------------------------------------------
// dbe_pkg
// Shared types, instruction format codes and helper functions of the Dalvik
// instruction encoder.
// ----------------------------------------------------------------------------
package dbe_pkg;

    typedef logic [4:0] t_fmt;

    // Instruction formats
    localparam t_fmt F_10X     = 5'd0;
    localparam t_fmt F_12X     = 5'd1;
    localparam t_fmt F_11N     = 5'd2;
    localparam t_fmt F_11X     = 5'd3;
    localparam t_fmt F_10T     = 5'd4;
    localparam t_fmt F_20T     = 5'd5;
    localparam t_fmt F_30T     = 5'd6;
    localparam t_fmt F_21C     = 5'd7;
    localparam t_fmt F_22C     = 5'd8;
    localparam t_fmt F_21T     = 5'd9;
    localparam t_fmt F_22T     = 5'd10;
    localparam t_fmt F_21S     = 5'd11;
    localparam t_fmt F_22B     = 5'd12;
    localparam t_fmt F_23X     = 5'd13;
    localparam t_fmt F_35C     = 5'd14;
    localparam t_fmt F_3RC     = 5'd15;
    localparam t_fmt F_31I     = 5'd16;
    localparam t_fmt F_31T     = 5'd18;
    localparam t_fmt F_21C_ALT = 5'd19;
    localparam t_fmt F_12X_ALT = 5'd21;
    localparam t_fmt F_22S     = 5'd22;
    localparam t_fmt F_22X     = 5'd23;
    localparam t_fmt F_32X     = 5'd24;
    localparam t_fmt F_31C     = 5'd25;
    localparam t_fmt F_51L     = 5'd26;

    // 21s opcodes that take the upper halves of the literal
    localparam logic [7:0] OP_CONST_HIGH16      = 8'h15;
    localparam logic [7:0] OP_CONST_WIDE_HIGH16 = 8'h19;

    localparam int          MAX_UNITS = 5;
    localparam int          ARGS_35C  = 5;

    typedef logic [2:0] t_ucnt;

    // Configuration register indexes
    localparam logic REG_FRAME = 1'b0;
    localparam logic REG_PARAM = 1'b1;

    typedef struct packed {
        logic [15:0] frame_register_count;
        logic [15:0] parameter_register_count;
        logic        restart;
    } t_cfg;

    // One encoded instruction, as queued between front and back
    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] words;
        logic [31:0]                pos;
        t_ucnt                      count;
        logic                       err;
    } t_rec;

    function automatic t_ucnt unit_count(input t_fmt fmt);
        t_ucnt n;
        unique case (fmt) inside
            F_20T, F_21C, F_21C_ALT, F_22C, F_21T, F_22T, F_21S, F_22B,
            F_22S, F_23X, F_22X:                               n = 3'd2;
            F_30T, F_35C, F_3RC, F_31I, F_31T, F_32X, F_31C:  n = 3'd3;
            F_51L:                                             n = 3'd5;
            default:                                           n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

[src/dbe_in_if.sv]
// ----------------------------------------------------------------------------
// dbe_in_if
// Instruction channel: one resolved Dalvik instruction per transaction.
// ----------------------------------------------------------------------------
interface dbe_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  format_code;
    logic [7:0]  opcode_byte;
    logic [7:0]  arg_count;
    logic [16:0] reg_a;
    logic [16:0] reg_b;
    logic [16:0] reg_c;
    logic [16:0] reg_d;
    logic [16:0] reg_e;
    logic signed [63:0] literal_value;
    logic [31:0] ref_index;
    logic        has_target;
    logic [31:0] target_position;

    modport source (
        output valid, format_code, opcode_byte, arg_count, reg_a, reg_b, reg_c,
               reg_d, reg_e, literal_value, ref_index, has_target, target_position,
        input  ready
    );
    modport sink (
        input  valid, format_code, opcode_byte, arg_count, reg_a, reg_b, reg_c,
               reg_d, reg_e, literal_value, ref_index, has_target, target_position,
        output ready
    );
endinterface

[src/dbe_out_if.sv]
// ----------------------------------------------------------------------------
// dbe_out_if
// Code unit channel: one encoded 16-bit code unit per transaction.
// ----------------------------------------------------------------------------
interface dbe_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic [31:0] unit_position;
    logic        limit_error;
    logic        last_unit;

    modport source (
        output valid, code_unit, unit_position, limit_error, last_unit,
        input  ready
    );
    modport sink (
        input  valid, code_unit, unit_position, limit_error, last_unit,
        output ready
    );
endinterface

[src/dbe_front.sv]
// ----------------------------------------------------------------------------
// dbe_front
// Accepts instructions, resolves registers, checks limits and packs the
// code units into one record; owns the running code position.
// ----------------------------------------------------------------------------
module dbe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dbe_pkg::t_cfg i_cfg,
    dbe_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_q_push,
    output dbe_pkg::t_rec o_q_rec
);
    import dbe_pkg::*;

    logic [31:0] r_position;
    logic [31:0] n_position;

    logic [31:0] base;
    logic [31:0] rel;
    logic [4:0][31:0] rr;
    logic [31:0] a, b, c;
    logic [7:0]  op;
    logic [7:0]  cnt;
    logic [63:0] lit;
    logic        err;
    logic [MAX_UNITS-1:0][15:0] w;
    logic        accept;

    function automatic logic [31:0] resolve(input logic [16:0] raw,
                                            input logic [31:0] bse);
        logic [31:0] v;
        if (raw[16]) begin
            v = bse + {16'd0, raw[15:0]};
        end else begin
            v = {15'd0, raw};
        end
        return v;
    endfunction

    function automatic logic over15(input logic [31:0] v);
        return |v[31:4];
    endfunction

    function automatic logic over255(input logic [31:0] v);
        return |v[31:8];
    endfunction

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    always_comb begin
        base  = {16'd0, i_cfg.frame_register_count}
              - {16'd0, i_cfg.parameter_register_count};
        rr[0] = resolve(i_in.reg_a, base);
        rr[1] = resolve(i_in.reg_b, base);
        rr[2] = resolve(i_in.reg_c, base);
        rr[3] = resolve(i_in.reg_d, base);
        rr[4] = resolve(i_in.reg_e, base);
        a     = rr[0];
        b     = rr[1];
        c     = rr[2];
        op    = i_in.opcode_byte;
        cnt   = i_in.arg_count;
        lit   = i_in.literal_value;
        rel   = i_in.has_target ? (i_in.target_position - r_position) : 32'd0;

        // Register limit checks per format
        err = 1'b0;
        unique case (i_in.format_code) inside
            F_12X, F_12X_ALT, F_22C, F_22T, F_22S: err = over15(a) || over15(b);
            F_11N: err = over15(a);
            F_11X, F_21C, F_21C_ALT, F_31C, F_21T, F_21S, F_31I, F_31T,
            F_51L, F_22X: err = over255(a);
            F_22B: err = over255(a) || over255(b);
            F_23X: err = over255(a) || over255(b) || over255(c);
            F_35C: begin
                for (int k = 0; k < ARGS_35C; k++) begin
                    if ((8'(k) < cnt) && over15(rr[k])) begin
                        err = 1'b1;
                    end
                end
            end
            default: err = 1'b0;
        endcase

        // Pack code units
        w    = '0;
        w[0] = {8'd0, op};
        unique case (i_in.format_code) inside
            F_12X, F_12X_ALT, F_22C, F_22T, F_22S: begin
                w[0] = {b[3:0], a[3:0], op};
                if (i_in.format_code == F_22C) begin
                    w[1] = i_in.ref_index[15:0];
                end else if (i_in.format_code == F_22T) begin
                    w[1] = rel[15:0];
                end else if (i_in.format_code == F_22S) begin
                    w[1] = lit[15:0];
                end
            end
            F_11N: w[0] = {lit[3:0], a[3:0], op};
            F_11X: w[0] = {a[7:0], op};
            F_10T: w[0] = {rel[7:0], op};
            F_20T: w[1] = rel[15:0];
            F_30T: begin
                w[1] = rel[15:0];
                w[2] = rel[31:16];
            end
            F_21C, F_21C_ALT: begin
                w[0] = {a[7:0], op};
                w[1] = i_in.ref_index[15:0];
            end
            F_21T: begin
                w[0] = {a[7:0], op};
                w[1] = rel[15:0];
            end
            F_21S: begin
                w[0] = {a[7:0], op};
                if (op == OP_CONST_HIGH16) begin
                    w[1] = lit[31:16];
                end else if (op == OP_CONST_WIDE_HIGH16) begin
                    w[1] = lit[63:48];
                end else begin
                    w[1] = lit[15:0];
                end
            end
            F_22B: begin
                w[0] = {a[7:0], op};
                w[1] = {lit[7:0], b[7:0]};
            end
            F_23X: begin
                w[0] = {a[7:0], op};
                w[1] = {c[7:0], b[7:0]};
            end
            F_35C: begin
                w[0] = {cnt[3:0], rr[4][3:0], op};
                w[1] = i_in.ref_index[15:0];
                w[2] = {rr[3][3:0], rr[2][3:0], rr[1][3:0], rr[0][3:0]};
            end
            F_3RC: begin
                w[0] = {cnt, op};
                w[1] = i_in.ref_index[15:0];
                w[2] = c[15:0];
            end
            F_31I: begin
                w[0] = {a[7:0], op};
                w[1] = lit[15:0];
                w[2] = lit[31:16];
            end
            F_31T: begin
                w[0] = {a[7:0], op};
                w[1] = rel[15:0];
                w[2] = rel[31:16];
            end
            F_22X: begin
                w[0] = {a[7:0], op};
                w[1] = b[15:0];
            end
            F_32X: begin
                w[1] = a[15:0];
                w[2] = b[15:0];
            end
            F_31C: begin
                w[0] = {a[7:0], op};
                w[1] = i_in.ref_index[15:0];
                w[2] = i_in.ref_index[31:16];
            end
            F_51L: begin
                w[0] = {a[7:0], op};
                w[1] = lit[15:0];
                w[2] = lit[31:16];
                w[3] = lit[47:32];
                w[4] = lit[63:48];
            end
            default: w[0] = {8'd0, op};
        endcase

        o_q_rec.pos = r_position;
        o_q_rec.err = err;
        if (err) begin
            o_q_rec.words = '0;
            o_q_rec.count = 3'd1;
        end else begin
            o_q_rec.words = w;
            o_q_rec.count = unit_count(i_in.format_code);
        end
        o_q_push = accept;

        // Advance position only on encoded instructions
        n_position = r_position;
        if (i_cfg.restart) begin
            n_position = '0;
        end else if (accept && !err) begin
            n_position = r_position + {29'd0, o_q_rec.count};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
        end else begin
            r_position <= n_position;
        end
    end

endmodule

[src/dbe_queue.sv]
// ----------------------------------------------------------------------------
// dbe_queue
// Small FIFO of encoded instruction records between front and back.
// ----------------------------------------------------------------------------
module dbe_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dbe_pkg::t_rec i_rec,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output dbe_pkg::t_rec o_rec
);
    import dbe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_rec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? bump(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = do_pop  ? bump(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

[src/dbe_back.sv]
// ----------------------------------------------------------------------------
// dbe_back
// Walks the code units of the queued record and drives them, one per
// cycle while o_out.ready allows, through an output register.
// ----------------------------------------------------------------------------
module dbe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  dbe_pkg::t_rec i_q_rec,
    output logic          o_q_pop,
    dbe_out_if.source     o_out
);
    import dbe_pkg::*;

    t_ucnt       r_unit, n_unit;
    logic        r_valid, n_valid;
    logic [15:0] r_code;
    logic [31:0] r_pos;
    logic        r_err;
    logic        r_last;
    logic        load;
    logic        is_last;

    assign load    = i_q_valid && (!r_valid || o_out.ready);
    assign is_last = ((r_unit + 1'b1) == i_q_rec.count);
    assign o_q_pop = load && is_last;

    always_comb begin
        n_unit = r_unit;
        if (load) begin
            n_unit = is_last ? '0 : r_unit + 1'b1;
        end
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_unit  <= n_unit;
            r_valid <= n_valid;
        end
    end

    // Payload register: load the selected unit
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code <= i_q_rec.words[r_unit];
            r_pos  <= i_q_rec.pos + {29'd0, r_unit};
            r_err  <= i_q_rec.err;
            r_last <= is_last;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.code_unit     = r_code;
    assign o_out.unit_position = r_pos;
    assign o_out.limit_error   = r_err;
    assign o_out.last_unit     = r_last;

endmodule

[src/dalvik_instruction_encoder.sv]
// ----------------------------------------------------------------------------
// dalvik_instruction_encoder
// Encodes resolved Dalvik instructions into 16-bit code units tagged with
// their position in the method.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one resolved instruction per transaction (valid/ready).
//   o_out carries one code unit per transaction; last_unit marks the final
//   unit of an instruction. A register limit violation yields one unit with
//   code_unit zero and limit_error set, and the position does not advance.
//   The APB port holds frame_register_count (0x0) and
//   parameter_register_count (0x4); writing the frame count restarts the
//   position at zero. Write configuration only while the block is idle.
// Timing:
//   The front takes one instruction per cycle while the queue has room.
//   After acceptance an instruction passes through the queue and the back's
//   output register before its first unit appears on o_out. The back drives
//   one code unit per cycle while o_out.ready is high; the sustained
//   instruction rate is set by the single output port and each unit count.
// Reset / stall:
//   Reset empties the queue and clears the output valid flag, the position
//   and both configuration registers. When o_out.ready is low the output
//   unit holds, the back stops, the queue fills and then i_in.ready drops.
// ----------------------------------------------------------------------------
module dalvik_instruction_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dbe_in_if.sink      i_in,
    dbe_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dbe_pkg::*;

    logic [15:0] r_frame, n_frame;
    logic [15:0] r_param, n_param;
    logic        cfg_wr;
    logic        reg_sel;
    t_cfg        cfg;

    logic        q_push, q_full, q_pop, q_valid;
    t_rec        q_in_rec, q_out_rec;

    // Configuration port: write on the access phase, word index from paddr
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_comb begin
        n_frame = r_frame;
        n_param = r_param;
        if (cfg_wr) begin
            unique case (reg_sel)
                REG_FRAME: n_frame = pwdata[15:0];
                REG_PARAM: n_param = pwdata[15:0];
                default:   n_frame = r_frame;
            endcase
        end
        unique case (reg_sel)
            REG_FRAME: prdata = {16'd0, r_frame};
            REG_PARAM: prdata = {16'd0, r_param};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_param <= '0;
        end else begin
            r_frame <= n_frame;
            r_param <= n_param;
        end
    end

    // Restart the position on a frame size write
    assign cfg.frame_register_count     = r_frame;
    assign cfg.parameter_register_count = r_param;
    assign cfg.restart                  = cfg_wr && (reg_sel == REG_FRAME);

    dbe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_rec  (q_in_rec)
    );

    dbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (q_in_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (q_out_rec)
    );

    dbe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_rec   (q_out_rec),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule
